// ----- src/ssd_pkg.sv -----
`timescale 1ns / 1ps

package ssd_pkg;

  // Result kinds as they appear on the output word
  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_SPAN    = 3'd1,
    KIND_DONE    = 3'd2,
    KIND_TRUNC   = 3'd3,
    KIND_BAD_DIM = 3'd4
  } kind_e;

  // Parser phase, one-hot
  typedef enum logic [5:0] {
    PH_WIDTH    = 6'b000001,
    PH_HEIGHT   = 6'b000010,
    PH_LINELEN  = 6'b000100,
    PH_SEGCOUNT = 6'b001000,
    PH_SEGMENT  = 6'b010000,
    PH_DONE     = 6'b100000
  } phase_e;

  // Running x saturates here
  localparam logic [12:0] XSat = 13'h1FFF;

  // Result queue geometry
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  // One queued result. For spans, dim_w carries the image width used for
  // clipping and count the raw pixel count; the back end clips and clears them.
  typedef struct packed {
    kind_e        kind;
    logic [15:0]  dim_w;
    logic [15:0]  dim_h;
    logic [11:0]  row;
    logic [11:0]  x_start;
    logic [15:0]  count;
    logic         last;
  } res_t;

endpackage

// ----- src/ssd_in_if.sv -----
`timescale 1ns / 1ps

interface ssd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

// ----- src/ssd_out_if.sv -----
`timescale 1ns / 1ps

interface ssd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [11:0] row;
  logic [11:0] x_start;
  logic [12:0] span_len;
  logic        last;

  modport source (output valid, output kind, output image_width, output image_height,
                  output row, output x_start, output span_len, output last,
                  input ready);
  modport sink   (input valid, input kind, input image_width, input image_height,
                  input row, input x_start, input span_len, input last,
                  output ready);
endinterface

// ----- src/shadow_sprite_span_decoder.sv -----
`timescale 1ns / 1ps

// Shadow sprite span decoder. Takes a sprite byte stream, one byte per word,
// and returns the header (or a bad-dimensions error), one word per visible
// shadow span clipped to the image width, and a final completion or
// truncation word with last set. Bytes after the final word are taken and
// dropped. A byte is taken every clock as long as the result queue holds no
// more than two unread words; it fills only when the output side stalls.
// A result passes through the result queue and then the output word register
// before it is presented on the output.
// Up to two results can come from one byte (a span then completion, or a
// header or span then truncation), drained one per clock when not stalled.
module shadow_sprite_span_decoder #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssd_in_if.sink    byte_i,
  ssd_out_if.source result_o
);

  logic          room;
  logic [1:0]    push_n;
  ssd_pkg::res_t push0;
  ssd_pkg::res_t push1;
  logic          pop;
  logic          head_valid;
  ssd_pkg::res_t head;

  ssd_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (byte_i.valid),
    .in_data_byte_i   (byte_i.data_byte),
    .in_end_of_data_i (byte_i.end_of_data),
    .room_i           (room),
    .in_ready_o       (byte_i.ready),
    .push_n_o         (push_n),
    .push0_o          (push0),
    .push1_o          (push1)
  );

  ssd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_n_i     (push_n),
    .push0_i      (push0),
    .push1_i      (push1),
    .pop_i        (pop),
    .room_o       (room),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  ssd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (result_o.valid),
    .out_ready_i    (result_o.ready),
    .kind_o         (result_o.kind),
    .image_width_o  (result_o.image_width),
    .image_height_o (result_o.image_height),
    .row_o          (result_o.row),
    .x_start_o      (result_o.x_start),
    .span_len_o     (result_o.span_len),
    .last_o         (result_o.last)
  );

endmodule

// ----- src/ssd_front.sv -----
`timescale 1ns / 1ps

module ssd_front #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    in_data_byte_i,
  input  logic          in_end_of_data_i,
  input  logic          room_i,
  output logic          in_ready_o,
  output logic [1:0]    push_n_o,
  output ssd_pkg::res_t push0_o,
  output ssd_pkg::res_t push1_o
);

  localparam logic [16:0] MaxDimW = 17'(MAX_DIM);

  ssd_pkg::phase_e phase_q, phase_d;
  logic [7:0]  low_q, low_d;
  logic        parity_q, parity_d;
  logic        grp_q, grp_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [12:0] row_q, row_d;
  logic [15:0] segs_q, segs_d;
  logic [12:0] start_q, start_d;
  logic [12:0] curx_q, curx_d;

  logic          accept;
  logic [15:0]   word;
  logic [16:0]   sum_off;
  logic [16:0]   sum_end;
  logic [12:0]   row_nxt;
  logic          bad_dim;
  logic          span_ok;
  logic          row_end;
  logic          vld_a, vld_b, vld_c;
  ssd_pkg::res_t res_a, res_b, res_c;

  assign in_ready_o = room_i;
  assign accept     = in_valid_i && room_i;
  assign word       = {in_data_byte_i, low_q};

  // Offset add at offset time, end add at count time; both saturate
  assign sum_off = {4'b0, curx_q} + {1'b0, word};
  assign sum_end = {4'b0, start_q} + {1'b0, word};
  assign row_nxt = row_q + 13'd1;
  assign bad_dim = (width_q == 16'd0) || (word == 16'd0) ||
                   ({1'b0, width_q} > MaxDimW) || ({1'b0, word} > MaxDimW);
  assign span_ok = ({3'b0, start_q} < width_q) && (word != 16'd0);

  // Parser: pairs bytes into words and walks the sprite layout
  always_comb begin
    phase_d  = phase_q;
    low_d    = low_q;
    parity_d = parity_q;
    grp_d    = grp_q;
    width_d  = width_q;
    height_d = height_q;
    row_d    = row_q;
    segs_d   = segs_q;
    start_d  = start_q;
    curx_d   = curx_q;
    row_end  = 1'b0;
    vld_a    = 1'b0;
    vld_b    = 1'b0;
    vld_c    = 1'b0;
    res_a    = '0;
    res_b    = '0;
    res_c    = '0;
    res_b.kind = ssd_pkg::KIND_DONE;
    res_b.last = 1'b1;
    res_c.kind = ssd_pkg::KIND_TRUNC;
    res_c.last = 1'b1;

    if (accept && (phase_q != ssd_pkg::PH_DONE)) begin
      if (!parity_q) begin
        low_d    = in_data_byte_i;
        parity_d = 1'b1;
      end else begin
        parity_d = 1'b0;
        case (phase_q)
          ssd_pkg::PH_WIDTH: begin
            width_d = word;
            phase_d = ssd_pkg::PH_HEIGHT;
          end
          ssd_pkg::PH_HEIGHT: begin
            height_d    = word;
            vld_a       = 1'b1;
            res_a.dim_w = width_q;
            res_a.dim_h = word;
            if (bad_dim) begin
              res_a.kind = ssd_pkg::KIND_BAD_DIM;
              res_a.last = 1'b1;
              phase_d    = ssd_pkg::PH_DONE;
            end else begin
              res_a.kind = ssd_pkg::KIND_HEADER;
              row_d      = '0;
              phase_d    = ssd_pkg::PH_LINELEN;
            end
          end
          ssd_pkg::PH_LINELEN: begin
            phase_d = ssd_pkg::PH_SEGCOUNT;
          end
          ssd_pkg::PH_SEGCOUNT: begin
            segs_d = word;
            curx_d = '0;
            grp_d  = 1'b0;
            if (word == 16'd0) begin
              row_end = 1'b1;
            end else begin
              phase_d = ssd_pkg::PH_SEGMENT;
            end
          end
          ssd_pkg::PH_SEGMENT: begin
            if (!grp_q) begin
              start_d = (sum_off[16:13] != 4'd0) ? ssd_pkg::XSat : sum_off[12:0];
              grp_d   = 1'b1;
            end else begin
              if (span_ok) begin
                vld_a         = 1'b1;
                res_a.kind    = ssd_pkg::KIND_SPAN;
                res_a.dim_w   = width_q;
                res_a.row     = row_q[11:0];
                res_a.x_start = start_q[11:0];
                res_a.count   = word;
              end
              curx_d = (sum_end[16:13] != 4'd0) ? ssd_pkg::XSat : sum_end[12:0];
              grp_d  = 1'b0;
              segs_d = segs_q - 16'd1;
              if (segs_q == 16'd1) begin
                row_end = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end

      // Row finished: next row or completion
      if (row_end) begin
        row_d = row_nxt;
        if ({3'b0, row_nxt} >= height_q) begin
          vld_b   = 1'b1;
          phase_d = ssd_pkg::PH_DONE;
        end else begin
          phase_d = ssd_pkg::PH_LINELEN;
        end
      end

      // Data ran out early
      if (in_end_of_data_i && (phase_d != ssd_pkg::PH_DONE)) begin
        vld_c   = 1'b1;
        phase_d = ssd_pkg::PH_DONE;
      end
    end
  end

  // Pack up to two results in order: word result, completion, truncation
  always_comb begin
    push_n_o = 2'({1'b0, vld_a} + {1'b0, vld_b} + {1'b0, vld_c});
    if (vld_a) begin
      push0_o = res_a;
      push1_o = vld_b ? res_b : res_c;
    end else begin
      push0_o = vld_b ? res_b : res_c;
      push1_o = res_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ssd_pkg::PH_WIDTH;
      low_q    <= '0;
      parity_q <= 1'b0;
      grp_q    <= 1'b0;
      width_q  <= '0;
      height_q <= '0;
      row_q    <= '0;
      segs_q   <= '0;
      start_q  <= '0;
      curx_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      low_q    <= low_d;
      parity_q <= parity_d;
      grp_q    <= grp_d;
      width_q  <= width_d;
      height_q <= height_d;
      row_q    <= row_d;
      segs_q   <= segs_d;
      start_q  <= start_d;
      curx_q   <= curx_d;
    end
  end

endmodule

// ----- src/ssd_queue.sv -----
`timescale 1ns / 1ps

module ssd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    push_n_i,
  input  ssd_pkg::res_t push0_i,
  input  ssd_pkg::res_t push1_i,
  input  logic          pop_i,
  output logic          room_o,
  output logic          head_valid_o,
  output ssd_pkg::res_t head_o
);

  ssd_pkg::res_t                 mem_q [ssd_pkg::QDepth];
  logic [ssd_pkg::QPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [ssd_pkg::QPtrW-1:0]     wr_ptr1;
  logic [ssd_pkg::QCntW-1:0]     cnt_q, cnt_d;

  assign wr_ptr1      = wr_ptr_q + 1'b1;
  assign room_o       = cnt_q <= ssd_pkg::QCntW'(ssd_pkg::QDepth - 2);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rd_ptr_q];
  assign cnt_d        = cnt_q + ssd_pkg::QCntW'(push_n_i) - ssd_pkg::QCntW'(pop_i);

  // Entry storage, up to two words written per cycle
  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr1] <= push1_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + ssd_pkg::QPtrW'(push_n_i);
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- src/ssd_back.sv -----
`timescale 1ns / 1ps

module ssd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  ssd_pkg::res_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [2:0]    kind_o,
  output logic [15:0]   image_width_o,
  output logic [15:0]   image_height_o,
  output logic [11:0]   row_o,
  output logic [11:0]   x_start_o,
  output logic [12:0]   span_len_o,
  output logic          last_o
);

  logic        valid_q;
  logic        load;
  logic        is_span;
  logic [12:0] room;
  logic [12:0] len;

  logic [2:0]  kind_q;
  logic [15:0] width_q;
  logic [15:0] height_q;
  logic [11:0] row_q;
  logic [11:0] xs_q;
  logic [12:0] len_q;
  logic        last_q;

  assign load  = !valid_q || out_ready_i;
  assign pop_o = head_valid_i && load;

  // Clip span to the image width; x_start is already inside it
  assign is_span = head_i.kind == ssd_pkg::KIND_SPAN;
  assign room    = head_i.dim_w[12:0] - {1'b0, head_i.x_start};
  assign len     = (head_i.count < {3'b0, room}) ? head_i.count[12:0] : room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= head_valid_i;
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q   <= head_i.kind;
      width_q  <= is_span ? 16'd0 : head_i.dim_w;
      height_q <= head_i.dim_h;
      row_q    <= head_i.row;
      xs_q     <= head_i.x_start;
      len_q    <= is_span ? len : 13'd0;
      last_q   <= head_i.last;
    end
  end

  assign out_valid_o    = valid_q;
  assign kind_o         = kind_q;
  assign image_width_o  = width_q;
  assign image_height_o = height_q;
  assign row_o          = row_q;
  assign x_start_o      = xs_q;
  assign span_len_o     = len_q;
  assign last_o         = last_q;

endmodule
